@@ rtl/bwc_pkg.sv @@
// Shared types and constants of the barcode whitelist counter.
// Used by the table memory, the sequencer, the top level and the checker.
package bwc_pkg;

  localparam int unsigned KEY_W       = 64;
  localparam int unsigned COUNT_W     = 32;
  localparam int unsigned TOTAL_W     = 40;
  localparam int unsigned IDX_W       = 10;
  localparam int unsigned BASES_W     = 6;
  localparam int unsigned MAX_BASES   = 32;
  localparam logic [BASES_W-1:0] BASES_RESET = 6'd16;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  typedef enum logic [1:0] {
    FUNC_LOAD    = 2'd0,
    FUNC_OBSERVE = 2'd1,
    FUNC_QUERY   = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DUP  = 2'd1,
    ST_FULL = 2'd2,
    ST_MISS = 2'd3
  } status_e;

  typedef struct packed {
    func_e              func;
    logic [KEY_W-1:0]   key;
    logic               unknown_base;
    logic [COUNT_W-1:0] start_count;
  } item_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [COUNT_W-1:0] count;
  } entry_t;

  typedef struct packed {
    status_e            status;
    logic [IDX_W-1:0]   entry_index;
    logic [COUNT_W-1:0] hit_count;
    logic [TOTAL_W-1:0] observed_total;
  } res_t;

endpackage

@@ rtl/bwc_table.sv @@
// Sorted whitelist table: one write port and one read port, read data registered.
// Depends on bwc_pkg for the entry type.
module bwc_table
  import bwc_pkg::*;
#(
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  entry_t                   wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output entry_t                   rdata_o
);

  entry_t mem_q [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/bwc_ctrl.sv @@
// Sequencer of the whitelist counter: binary search, insertion shift and count update.
// Depends on bwc_pkg; drives the ports of bwc_table.
module bwc_ctrl
  import bwc_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 1024
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             item_valid_i,
  input  item_t                            item_i,
  output logic                             item_ready_o,
  output logic                             res_valid_o,
  output res_t                             res_o,
  input  logic                             res_ready_i,
  output logic                             mem_we_o,
  output logic [$clog2(TABLE_ENTRIES)-1:0] mem_waddr_o,
  output entry_t                           mem_wdata_o,
  output logic                             mem_re_o,
  output logic [$clog2(TABLE_ENTRIES)-1:0] mem_raddr_o,
  input  entry_t                           mem_rdata_i
);

  localparam int unsigned AW = $clog2(TABLE_ENTRIES);
  localparam int unsigned LW = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned EW = (LW > IDX_W) ? LW : IDX_W;
  localparam logic [LW-1:0] FULL_LEVEL = LW'(TABLE_ENTRIES);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_DECIDE,
    S_SHIFT,
    S_WRITE,
    S_DONE
  } state_e;

  state_e             state_q, state_d;
  item_t              item_q, item_d;
  logic [LW-1:0]      lo_q, lo_d, hi_q, hi_d, mid_q, mid_d, sh_q, sh_d;
  logic               pend_q, pend_d;
  logic [LW-1:0]      loaded_q, loaded_d;
  logic [TOTAL_W-1:0] total_q, total_d;
  status_e            status_q, status_d;
  logic [IDX_W-1:0]   ridx_q, ridx_d;
  logic [COUNT_W-1:0] rcnt_q, rcnt_d;

  logic               key_lt, found;
  logic [LW-1:0]      lo_s, hi_s, mid_s, span_s;
  logic [LW-1:0]      last_idx, sh_inc, sh_dec, mid_inc;
  logic [EW-1:0]      p_ext;
  logic [COUNT_W-1:0] cnt_inc;
  logic [TOTAL_W:0]   sum_one, sum_start;
  logic [TOTAL_W-1:0] total_one, total_start;

  assign key_lt   = mem_rdata_i.key < item_q.key;
  assign mid_inc  = mid_q + LW'(1);
  assign last_idx = loaded_q - LW'(1);
  assign sh_inc   = sh_q + LW'(1);
  assign sh_dec   = sh_q - LW'(1);
  assign p_ext    = EW'(lo_q);
  assign found    = (lo_q < loaded_q) && (mem_rdata_i.key == item_q.key);
  assign cnt_inc  = (mem_rdata_i.count == COUNT_MAX) ? COUNT_MAX
                                                     : mem_rdata_i.count + COUNT_W'(1);

  // Bit TOTAL_W of either sum is set exactly when the total would pass its ceiling.
  assign sum_one     = {1'b0, total_q} + (TOTAL_W + 1)'(1);
  assign sum_start   = {1'b0, total_q} + (TOTAL_W + 1)'(item_q.start_count);
  assign total_one   = sum_one[TOTAL_W] ? TOTAL_MAX : sum_one[TOTAL_W-1:0];
  assign total_start = sum_start[TOTAL_W] ? TOTAL_MAX : sum_start[TOTAL_W-1:0];

  // One search step: narrow the window with the entry read last cycle, then pick the
  // next midpoint.
  always_comb begin
    lo_s = lo_q;
    hi_s = hi_q;
    if (pend_q) begin
      if (key_lt) begin
        lo_s = mid_inc;
      end else begin
        hi_s = mid_q;
      end
    end
    span_s = hi_s - lo_s;
    mid_s  = lo_s + (span_s >> 1);
  end

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    sh_d        = sh_q;
    pend_d      = pend_q;
    loaded_d    = loaded_q;
    total_d     = total_q;
    status_d    = status_q;
    ridx_d      = ridx_q;
    rcnt_d      = rcnt_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = lo_q[AW-1:0];
    mem_wdata_o = mem_rdata_i;
    mem_re_o    = 1'b0;
    mem_raddr_o = mid_s[AW-1:0];

    case (state_q)
      S_IDLE: begin
        if (item_valid_i) begin
          item_d  = item_i;
          lo_d    = '0;
          hi_d    = loaded_q;
          pend_d  = 1'b0;
          state_d = S_SEARCH;
        end
      end

      S_SEARCH: begin
        lo_d = lo_s;
        hi_d = hi_s;
        if (lo_s < hi_s) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = mid_s[AW-1:0];
          mid_d       = mid_s;
          pend_d      = 1'b1;
        end else begin
          // The window has closed on the insertion point; fetch that entry if it exists.
          mem_re_o    = lo_s < loaded_q;
          mem_raddr_o = lo_s[AW-1:0];
          pend_d      = 1'b0;
          state_d     = S_DECIDE;
        end
      end

      S_DECIDE: begin
        status_d = ST_MISS;
        ridx_d   = '0;
        rcnt_d   = '0;
        state_d  = S_DONE;
        case (item_q.func)
          FUNC_LOAD: begin
            if (found) begin
              status_d = ST_DUP;
              ridx_d   = p_ext[IDX_W-1:0];
              rcnt_d   = mem_rdata_i.count;
            end else if (loaded_q == FULL_LEVEL) begin
              status_d = ST_FULL;
            end else if (loaded_q != lo_q) begin
              mem_re_o    = 1'b1;
              mem_raddr_o = last_idx[AW-1:0];
              sh_d        = last_idx;
              state_d     = S_SHIFT;
            end else begin
              state_d = S_WRITE;
            end
          end
          default: begin
            if (!item_q.unknown_base && found) begin
              status_d = ST_OK;
              ridx_d   = p_ext[IDX_W-1:0];
              if (item_q.func == FUNC_OBSERVE) begin
                mem_we_o          = 1'b1;
                mem_waddr_o       = lo_q[AW-1:0];
                mem_wdata_o.key   = mem_rdata_i.key;
                mem_wdata_o.count = cnt_inc;
                total_d           = total_one;
                rcnt_d            = cnt_inc;
              end else begin
                rcnt_d = mem_rdata_i.count;
              end
            end
          end
        endcase
      end

      S_SHIFT: begin
        // Move the entry read last cycle up by one while fetching the one below it;
        // the read and the write never address the same entry in one cycle.
        mem_we_o    = 1'b1;
        mem_waddr_o = sh_inc[AW-1:0];
        mem_wdata_o = mem_rdata_i;
        if (sh_q == lo_q) begin
          state_d = S_WRITE;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = sh_dec[AW-1:0];
          sh_d        = sh_dec;
        end
      end

      S_WRITE: begin
        mem_we_o          = 1'b1;
        mem_waddr_o       = lo_q[AW-1:0];
        mem_wdata_o.key   = item_q.key;
        mem_wdata_o.count = item_q.start_count;
        loaded_d          = loaded_q + LW'(1);
        total_d           = total_start;
        status_d          = ST_OK;
        ridx_d            = p_ext[IDX_W-1:0];
        rcnt_d            = item_q.start_count;
        state_d           = S_DONE;
      end

      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      pend_q   <= 1'b0;
      loaded_q <= '0;
      total_q  <= '0;
    end else begin
      state_q  <= state_d;
      pend_q   <= pend_d;
      loaded_q <= loaded_d;
      total_q  <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    mid_q    <= mid_d;
    sh_q     <= sh_d;
    status_q <= status_d;
    ridx_q   <= ridx_d;
    rcnt_q   <= rcnt_d;
  end

  assign item_ready_o         = state_q == S_IDLE;
  assign res_valid_o          = state_q == S_DONE;
  assign res_o.status         = status_q;
  assign res_o.entry_index    = ridx_q;
  assign res_o.hit_count      = rcnt_q;
  assign res_o.observed_total = total_q;

endmodule

@@ rtl/barcode_whitelist_counter.sv @@
// Barcode whitelist counter: stream wrapper, length register and output register.
// Depends on bwc_pkg, bwc_ctrl and bwc_table.
//
// Items arrive on the s_axis channel: tuser selects load, observe or query and flags an
// unknown base; tdata carries the packed key and the starting count. Each item gives
// one result on the m_axis channel: tuser holds the status, tdata the sorted index, the
// entry's count and the running observed total.
// The cfg channel writes the barcode length in bases; it is always ready. It must be written
// only while no item is in flight; the block itself does not enforce this.
// Items are handled one at a time. An observe or query runs a binary search over the
// loaded entries, and the search issues one table read a cycle on the single read port.
// A load that stores its key also moves each entry above its slot up by one to open it
// and then writes the new entry; a rejected load takes no longer than a query.
// The next item is taken the cycle after its predecessor's result enters the output
// register. A stalled receiver therefore holds one result in that register and at most
// one more finished result in the sequencer before the input side stops.
// Reset empties the table and clears the total at once; the table contents need no
// clearing pass as only loaded entries are ever read.
module barcode_whitelist_counter
  import bwc_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  // tdata: key [63:0], start_count [95:64]
  input  logic [95:0]        s_axis_tdata_i,
  // tuser: func [1:0], unknown_base [2]
  input  logic [2:0]         s_axis_tuser_i,
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  // tdata: entry_index [9:0], hit_count [41:10], observed_total [81:42], zeros [87:82]
  output logic [87:0]        m_axis_tdata_o,
  // tuser: status [1:0]
  output logic [1:0]         m_axis_tuser_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [BASES_W-1:0] cfg_data_i
);

  localparam int unsigned AW = $clog2(TABLE_ENTRIES);

  logic [BASES_W-1:0] bases_q;
  logic [BASES_W:0]   bases_eff;
  logic [KEY_W-1:0]   key_mask;
  item_t              item;
  logic               res_valid, res_ready;
  res_t               res;
  logic               out_valid_q;
  logic [87:0]        out_data_q;
  logic [1:0]         out_user_q;

  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  entry_t             mem_wdata, mem_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bases_q <= BASES_RESET;
    end else if (cfg_valid_i) begin
      bases_q <= cfg_data_i;
    end
  end

  // A length of zero acts as one base; lengths past the widest key act as the widest.
  always_comb begin
    if (bases_q == '0) begin
      bases_eff = (BASES_W + 1)'(1);
    end else if (bases_q > BASES_W'(MAX_BASES)) begin
      bases_eff = (BASES_W + 1)'(MAX_BASES);
    end else begin
      bases_eff = {1'b0, bases_q};
    end
    for (int j = 0; j < KEY_W; j++) begin
      key_mask[j] = (BASES_W + 2)'(j) < {bases_eff, 1'b0};
    end
  end

  assign item.func         = func_e'(s_axis_tuser_i[1:0]);
  assign item.unknown_base = s_axis_tuser_i[2];
  assign item.key          = s_axis_tdata_i[63:0] & key_mask;
  assign item.start_count  = s_axis_tdata_i[95:64];

  bwc_ctrl #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(s_axis_tvalid_i),
    .item_i      (item),
    .item_ready_o(s_axis_tready_o),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  bwc_table #(
    .DEPTH(TABLE_ENTRIES)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_data_q <= {6'b0, res.observed_total, res.hit_count, res.entry_index};
      out_user_q <= res.status;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

endmodule

@@ rtl/bwc_checker.sv @@
// Port-level checks of the barcode whitelist counter, bound to its top level.
// Depends on bwc_pkg for the status codes.
module bwc_checker
  import bwc_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               s_axis_tvalid_i,
  input logic               s_axis_tready_o,
  input logic               m_axis_tvalid_o,
  input logic               m_axis_tready_i,
  input logic [87:0]        m_axis_tdata_o,
  input logic [1:0]         m_axis_tuser_o
);

  // A stalled result stays on the bus unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  // Items are worked on one at a time, so an accepted transaction closes the input.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input ready straight after a transaction");

  // A full-table rejection reports neither an index nor a count.
  a_full_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == ST_FULL) |-> m_axis_tdata_o[41:0] == '0)
    else $error("full status with index or count");

  // A miss reports neither an index nor a count.
  a_miss_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == ST_MISS) |-> m_axis_tdata_o[41:0] == '0)
    else $error("miss status with index or count");

endmodule

bind barcode_whitelist_counter bwc_checker u_bwc_checker (.*);
